// ===== hdl/bbse_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes of the buffered block store with erase.
package bbse_pkg;

  localparam int LBA_COUNT   = 128;
  localparam int QUEUE_DEPTH = 10;
  localparam int MAX_ERASE   = 10;

  localparam int LBA_W   = 7;
  localparam int DATA_W  = 32;
  localparam int ELEN_W  = 4;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int PCNT_W  = 4;

  localparam int ADDR_W = (LBA_COUNT > 1) ? $clog2(LBA_COUNT) : 1;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ERASE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ADDR_ERR  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ERASE_ERR = 2'd2;

  // One pending command; an erase keeps its length in the low data bits.
  typedef struct packed {
    logic              is_erase;
    logic [LBA_W-1:0]  lba;
    logic [DATA_W-1:0] data;
  } q_entry_t;

  // Request from the sequencer to the word store.
  typedef struct packed {
    logic              wr_en;
    logic              clr_en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } store_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_MEM_RD,
    ST_MEM_DATA,
    ST_DRN_RD,
    ST_DRN_AP,
    ST_ERASE,
    ST_ENQ,
    ST_RESP
  } state_t;

endpackage

// ===== hdl/bbse_in_if.sv =====
`timescale 1ns / 1ps
// Command channel of the buffered block store.
interface bbse_in_if;
  logic                          valid;
  logic                          ready;
  logic [bbse_pkg::FUNC_W-1:0]   func;
  logic [bbse_pkg::LBA_W-1:0]    lba;
  logic [bbse_pkg::DATA_W-1:0]   write_value;
  logic [bbse_pkg::ELEN_W-1:0]   erase_length;

  modport source (output valid, func, lba, write_value, erase_length, input ready);
  modport sink   (input valid, func, lba, write_value, erase_length, output ready);
endinterface

// ===== hdl/bbse_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the buffered block store.
interface bbse_out_if;
  logic                          valid;
  logic                          ready;
  logic [bbse_pkg::DATA_W-1:0]   read_data;
  logic [bbse_pkg::STAT_W-1:0]   status;
  logic                          drained;
  logic [bbse_pkg::PCNT_W-1:0]   pending_count;

  modport source (output valid, read_data, status, drained, pending_count, input ready);
  modport sink   (input valid, read_data, status, drained, pending_count, output ready);
endinterface

// ===== hdl/bbse_store.sv =====
`timescale 1ns / 1ps
// Word store with per-word valid bits; an invalid word reads as zero.
module bbse_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbse_pkg::store_req_t          req,
  output logic [bbse_pkg::DATA_W-1:0]   rdata
);

  logic [bbse_pkg::DATA_W-1:0] mem [bbse_pkg::LBA_COUNT];
  logic [bbse_pkg::LBA_COUNT-1:0] vld_r;
  logic [bbse_pkg::DATA_W-1:0] mem_q_r;
  logic                        vld_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    mem_q_r <= mem[req.addr];
  end

  // Erasing a word only drops its valid bit, so it reads as zero afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end else if (req.clr_en) begin
        vld_r[req.addr] <= 1'b0;
      end
      vld_q_r <= vld_r[req.addr];
    end
  end

  assign rdata = vld_q_r ? mem_q_r : '0;

endmodule

// ===== hdl/buffered_block_store_with_erase_unit.sv =====
`timescale 1ns / 1ps
// Buffered block store: command queue, sequencer and word store.
// A rejected item, or a flush of an empty queue, goes straight to the result register; a write
// or erase is queued, and a read searches the pending entries newest first and reaches the store
// only if none covers its address. A flush, or a write or erase into a full queue, first drains
// the queue through the single store port and the one-entry queue read, and a result waits while
// the result register is held. One item at a time; rst_n (synchronous, active low) empties queue and store.
module buffered_block_store_with_erase_unit (
  input  logic       clk,
  input  logic       rst_n,
  bbse_in_if.sink    in_if,
  bbse_out_if.source out_if
);

  bbse_pkg::state_t state_r, state_nxt;

  logic [bbse_pkg::FUNC_W-1:0] cmd_func_r;
  logic [bbse_pkg::LBA_W-1:0]  cmd_lba_r;
  logic [bbse_pkg::DATA_W-1:0] cmd_val_r;
  logic [bbse_pkg::ELEN_W-1:0] cmd_len_r;

  logic [bbse_pkg::CNT_W-1:0]  pend_r, pend_nxt;
  logic [bbse_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [bbse_pkg::ELEN_W-1:0] off_r, off_nxt;

  logic [bbse_pkg::DATA_W-1:0] rdata_r, rdata_nxt;
  logic [bbse_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                        drained_r, drained_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [bbse_pkg::DATA_W-1:0] out_data_r;
  logic [bbse_pkg::STAT_W-1:0] out_status_r;
  logic                        out_drained_r;
  logic [bbse_pkg::PCNT_W-1:0] out_pcnt_r;

  bbse_pkg::q_entry_t q_mem [bbse_pkg::QUEUE_DEPTH];
  bbse_pkg::q_entry_t q_rd_r;
  bbse_pkg::q_entry_t q_wdata;
  logic                        q_wr_en, q_rd_en;
  logic [bbse_pkg::QIDX_W-1:0] q_rd_idx;

  bbse_pkg::store_req_t        st_req;
  logic [bbse_pkg::DATA_W-1:0] st_rdata;

  logic accept, out_load;
  logic lba_oob, erase_bad, q_full, drn_last, erase_last, srch_hit;
  logic [bbse_pkg::LBA_W:0] srch_diff;
  logic [15:0]              erase_addr;
  bbse_pkg::state_t         drn_done_st;

  assign accept   = in_if.valid && in_if.ready;
  assign out_load = (state_r == bbse_pkg::ST_RESP) && (!out_valid_r || out_if.ready);

  assign lba_oob   = 16'(in_if.lba) >= 16'(bbse_pkg::LBA_COUNT);
  assign erase_bad = (in_if.erase_length == '0)
                  || (16'(in_if.erase_length) > 16'(bbse_pkg::MAX_ERASE))
                  || (16'(in_if.lba) + 16'(in_if.erase_length) > 16'(bbse_pkg::LBA_COUNT));
  assign q_full    = 32'(pend_r) >= 32'(bbse_pkg::QUEUE_DEPTH);

  assign drn_last    = (idx_r + 1'b1) == pend_r;
  assign erase_last  = (off_r + 1'b1) == q_rd_r.data[bbse_pkg::ELEN_W-1:0];
  assign drn_done_st = (cmd_func_r == bbse_pkg::FUNC_FLUSH) ? bbse_pkg::ST_RESP
                                                           : bbse_pkg::ST_ENQ;

  // Newest-first search: an erase covers the address when it lies within its range.
  assign srch_diff = {1'b0, cmd_lba_r} - {1'b0, q_rd_r.lba};
  assign srch_hit  = q_rd_r.is_erase
                   ? ((cmd_lba_r >= q_rd_r.lba) &&
                      (srch_diff < (bbse_pkg::LBA_W + 1)'(q_rd_r.data[bbse_pkg::ELEN_W-1:0])))
                   : (q_rd_r.lba == cmd_lba_r);

  assign erase_addr = 16'(q_rd_r.lba) + 16'(off_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbse_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_if.func == bbse_pkg::FUNC_FLUSH) begin
            state_nxt = (pend_r != '0) ? bbse_pkg::ST_DRN_RD : bbse_pkg::ST_RESP;
          end else if (lba_oob) begin
            state_nxt = bbse_pkg::ST_RESP;
          end else if (in_if.func == bbse_pkg::FUNC_READ) begin
            state_nxt = (pend_r != '0) ? bbse_pkg::ST_SRCH_RD : bbse_pkg::ST_MEM_RD;
          end else if ((in_if.func == bbse_pkg::FUNC_ERASE) && erase_bad) begin
            state_nxt = bbse_pkg::ST_RESP;
          end else begin
            state_nxt = q_full ? bbse_pkg::ST_DRN_RD : bbse_pkg::ST_ENQ;
          end
        end
      end
      bbse_pkg::ST_SRCH_RD:  state_nxt = bbse_pkg::ST_SRCH_CHK;
      bbse_pkg::ST_SRCH_CHK: begin
        if (srch_hit) begin
          state_nxt = bbse_pkg::ST_RESP;
        end else if (idx_r == '0) begin
          state_nxt = bbse_pkg::ST_MEM_RD;
        end else begin
          state_nxt = bbse_pkg::ST_SRCH_RD;
        end
      end
      bbse_pkg::ST_MEM_RD:   state_nxt = bbse_pkg::ST_MEM_DATA;
      bbse_pkg::ST_MEM_DATA: state_nxt = bbse_pkg::ST_RESP;
      bbse_pkg::ST_DRN_RD:   state_nxt = bbse_pkg::ST_DRN_AP;
      bbse_pkg::ST_DRN_AP: begin
        if (q_rd_r.is_erase) begin
          state_nxt = bbse_pkg::ST_ERASE;
        end else begin
          state_nxt = drn_last ? drn_done_st : bbse_pkg::ST_DRN_RD;
        end
      end
      bbse_pkg::ST_ERASE: begin
        if (erase_last) begin
          state_nxt = drn_last ? drn_done_st : bbse_pkg::ST_DRN_RD;
        end
      end
      bbse_pkg::ST_ENQ:  state_nxt = bbse_pkg::ST_RESP;
      bbse_pkg::ST_RESP: begin
        if (out_load) begin
          state_nxt = bbse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bbse_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and next values.
  always_comb begin
    pend_nxt    = pend_r;
    idx_nxt     = idx_r;
    off_nxt     = off_r;
    rdata_nxt   = rdata_r;
    status_nxt  = status_r;
    drained_nxt = drained_r;
    q_wr_en     = 1'b0;
    q_rd_en     = 1'b0;
    q_rd_idx    = bbse_pkg::QIDX_W'(idx_r);
    q_wdata.is_erase = (cmd_func_r == bbse_pkg::FUNC_ERASE);
    q_wdata.lba      = cmd_lba_r;
    q_wdata.data     = (cmd_func_r == bbse_pkg::FUNC_ERASE)
                     ? bbse_pkg::DATA_W'(cmd_len_r) : cmd_val_r;
    st_req.wr_en  = 1'b0;
    st_req.clr_en = 1'b0;
    st_req.addr   = bbse_pkg::ADDR_W'(cmd_lba_r);
    st_req.wdata  = q_rd_r.data;
    unique case (state_r)
      bbse_pkg::ST_IDLE: begin
        rdata_nxt   = '0;
        drained_nxt = 1'b0;
        status_nxt  = bbse_pkg::STATUS_OK;
        idx_nxt     = (in_if.func == bbse_pkg::FUNC_READ) ? pend_r : '0;
        if (in_if.func != bbse_pkg::FUNC_FLUSH) begin
          if (lba_oob) begin
            status_nxt = bbse_pkg::STATUS_ADDR_ERR;
          end else if ((in_if.func == bbse_pkg::FUNC_ERASE) && erase_bad) begin
            status_nxt = bbse_pkg::STATUS_ERASE_ERR;
          end
        end
      end
      bbse_pkg::ST_SRCH_RD: begin
        q_rd_en  = 1'b1;
        q_rd_idx = bbse_pkg::QIDX_W'(idx_r - 1'b1);
        idx_nxt  = idx_r - 1'b1;
      end
      bbse_pkg::ST_SRCH_CHK: begin
        if (srch_hit) begin
          rdata_nxt = q_rd_r.is_erase ? '0 : q_rd_r.data;
        end
      end
      bbse_pkg::ST_MEM_DATA: rdata_nxt = st_rdata;
      bbse_pkg::ST_DRN_RD: begin
        q_rd_en = 1'b1;
        off_nxt = '0;
      end
      bbse_pkg::ST_DRN_AP: begin
        if (!q_rd_r.is_erase) begin
          st_req.wr_en = 16'(q_rd_r.lba) < 16'(bbse_pkg::LBA_COUNT);
          st_req.addr  = bbse_pkg::ADDR_W'(q_rd_r.lba);
          idx_nxt      = idx_r + 1'b1;
          if (drn_last) begin
            pend_nxt    = '0;
            drained_nxt = 1'b1;
          end
        end
      end
      bbse_pkg::ST_ERASE: begin
        st_req.clr_en = erase_addr < 16'(bbse_pkg::LBA_COUNT);
        st_req.addr   = bbse_pkg::ADDR_W'(erase_addr);
        off_nxt       = off_r + 1'b1;
        if (erase_last) begin
          idx_nxt = idx_r + 1'b1;
          if (drn_last) begin
            pend_nxt    = '0;
            drained_nxt = 1'b1;
          end
        end
      end
      bbse_pkg::ST_ENQ: begin
        q_wr_en  = 1'b1;
        pend_nxt = pend_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbse_pkg::ST_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func_r <= in_if.func;
      cmd_lba_r  <= in_if.lba;
      cmd_val_r  <= in_if.write_value;
      cmd_len_r  <= in_if.erase_length;
    end
    idx_r     <= idx_nxt;
    off_r     <= off_nxt;
    rdata_r   <= rdata_nxt;
    status_r  <= status_nxt;
    drained_r <= drained_nxt;
    if (out_load) begin
      out_data_r    <= rdata_r;
      out_status_r  <= status_r;
      out_drained_r <= drained_r;
      out_pcnt_r    <= bbse_pkg::PCNT_W'(pend_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      q_mem[bbse_pkg::QIDX_W'(pend_r)] <= q_wdata;
    end
    if (q_rd_en) begin
      q_rd_r <= q_mem[q_rd_idx];
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);

  bbse_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rdata (st_rdata)
  );

  assign in_if.ready          = (state_r == bbse_pkg::ST_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.read_data     = out_data_r;
  assign out_if.status        = out_status_r;
  assign out_if.drained       = out_drained_r;
  assign out_if.pending_count = out_pcnt_r;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pend_r) <= 32'(bbse_pkg::QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_if.ready)
    else $error("new item taken while previous item is in progress");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(state_r == bbse_pkg::ST_RESP))
    else $error("result raised outside the response state");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.drained) |-> (out_if.pending_count <= 4'd1))
    else $error("drained result leaves more than one pending item");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status != bbse_pkg::STATUS_OK))
      |-> (!out_if.drained && (out_if.read_data == '0)))
    else $error("rejected item drained the queue or returned data");
`endif

endmodule
